FILE: sv/itrd_pkg.sv
// shared constants and types for the radix digit converter
`timescale 1ns / 1ps

package itrd_pkg;

    // width of the integer taken in, and of the port that carries it
    localparam int IN_WIDTH    = 63;
    localparam int VALUE_WIDTH = 63;
    localparam int BIT_W       = $clog2(VALUE_WIDTH);

    // digit store
    localparam int STORE_DEPTH = 63;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
    localparam int DIGIT_W     = 4;

    // radix register and its limits
    localparam int RADIX_W = 4;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX     = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = RADIX_W'(10);

    // output character
    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

    // descriptor of a finished conversion handed to the emitter
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } t_job;

endpackage

FILE: sv/itrd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module itrd_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/itrd_front.sv
// front end: takes a word, saturates the radix and extracts digits by serial division
`timescale 1ns / 1ps

module itrd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [itrd_pkg::IN_WIDTH-1:0]  i_value,
    input  logic [itrd_pkg::RADIX_W-1:0]   i_radix,
    output logic                           o_idle,
    output itrd_pkg::t_job                 o_job,
    input  logic                           i_job_ready,
    output logic                           o_we,
    output logic [itrd_pkg::ADDR_W-1:0]    o_waddr,
    output logic [itrd_pkg::DIGIT_W-1:0]   o_wdata
);

    import itrd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_HAND = 2'd2;

    localparam logic [BIT_W-1:0]   BIT_LAST   = BIT_W'(VALUE_WIDTH - 1);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(STORE_DEPTH);

    logic [1:0]             r_state, n_state;
    logic [VALUE_WIDTH-1:0] r_quot,  n_quot;
    logic [DIGIT_W-1:0]     r_rem,   n_rem;
    logic [RADIX_W-1:0]     r_radix, n_radix;
    logic [BIT_W-1:0]       r_bit,   n_bit;
    logic [COUNT_W-1:0]     r_count, n_count;

    logic [VALUE_WIDTH-1:0] value_in;
    logic                   value_zero;
    logic [RADIX_W-1:0]     radix_eff;
    logic [DIGIT_W:0]       rem_ext;
    logic [DIGIT_W:0]       rem_diff;
    logic                   rem_ge;
    logic [DIGIT_W-1:0]     rem_new;
    logic [VALUE_WIDTH-1:0] quot_new;
    logic [COUNT_W-1:0]     count_inc;

    // input classification and radix saturation
    always_comb begin
        value_in   = i_value[VALUE_WIDTH-1:0];
        value_zero = (value_in == '0);
        if (i_radix < RADIX_MIN) begin
            radix_eff = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_eff = RADIX_MAX;
        end else begin
            radix_eff = i_radix;
        end
    end

    // one restoring division step per cycle
    always_comb begin
        rem_ext  = {r_rem, r_quot[VALUE_WIDTH-1]};
        rem_diff = rem_ext - {1'b0, r_radix};
        rem_ge   = (rem_ext >= {1'b0, r_radix});
        rem_new  = rem_ge ? rem_diff[DIGIT_W-1:0] : rem_ext[DIGIT_W-1:0];
        quot_new = {r_quot[VALUE_WIDTH-2:0], rem_ge};
        count_inc = r_count + COUNT_W'(1);
    end

    // digit store writes
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_count[ADDR_W-1:0];
        o_wdata = rem_new;
        if (r_state == S_IDLE) begin
            o_we    = i_start && value_zero;
            o_waddr = '0;
            o_wdata = '0;
        end else if (r_state == S_DIV) begin
            o_we = (r_bit == '0);
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_radix = r_radix;
        n_bit   = r_bit;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_quot  = value_in;
                    n_rem   = '0;
                    n_radix = radix_eff;
                    n_bit   = BIT_LAST;
                    if (value_zero) begin
                        n_count = COUNT_W'(1);
                        n_state = S_HAND;
                    end else begin
                        n_count = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_quot = quot_new;
                n_rem  = rem_new;
                n_bit  = r_bit - BIT_W'(1);
                if (r_bit == '0) begin
                    n_count = count_inc;
                    n_rem   = '0;
                    n_bit   = BIT_LAST;
                    if (quot_new == '0 || count_inc == COUNT_FULL) begin
                        n_state = S_HAND;
                    end
                end
            end
            S_HAND: begin
                if (i_job_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_quot  <= n_quot;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_bit   <= n_bit;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_job.valid = (r_state == S_HAND);
    assign o_job.count = r_count;

endmodule

FILE: sv/itrd_back.sv
// back end: reads buffered digits most significant first and emits characters
`timescale 1ns / 1ps

module itrd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  itrd_pkg::t_job                i_job,
    output logic                          o_job_ready,
    output logic                          o_busy,
    output logic                          o_re,
    output logic [itrd_pkg::ADDR_W-1:0]   o_raddr,
    input  logic [itrd_pkg::DIGIT_W-1:0]  i_rdata,
    output logic                          o_valid,
    output logic [itrd_pkg::CHAR_W-1:0]   o_digit_char,
    output logic                          o_last_digit
);

    import itrd_pkg::*;

    logic              r_active, n_active;
    logic [ADDR_W-1:0] r_ptr,    n_ptr;
    logic              r_pend,   n_pend;
    logic              r_last,   n_last;
    logic [COUNT_W-1:0] job_top;

    assign o_job_ready = !r_active;
    assign job_top     = i_job.count - COUNT_W'(1);

    // read pointer walks down from the top digit
    always_comb begin
        n_active = r_active;
        n_ptr    = r_ptr;
        n_pend   = 1'b0;
        n_last   = r_last;
        if (r_active) begin
            n_pend = 1'b1;
            n_last = (r_ptr == '0);
            if (r_ptr == '0) begin
                n_active = 1'b0;
            end else begin
                n_ptr = r_ptr - ADDR_W'(1);
            end
        end else if (i_job.valid) begin
            n_active = 1'b1;
            n_ptr    = job_top[ADDR_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_pend   <= n_pend;
        end
    end

    // pointer and last mark
    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_last <= n_last;
    end

    assign o_re    = r_active;
    assign o_raddr = r_ptr;
    assign o_busy  = r_active || r_pend;

    // output word, in the cycle after the read
    assign o_valid      = r_pend;
    assign o_digit_char = ASCII_ZERO + CHAR_W'(i_rdata);
    assign o_last_digit = r_last;

endmodule

FILE: sv/integer_to_radix_digits.sv
// top level of the integer to radix digit converter
`timescale 1ns / 1ps
//
// Converts one non-negative integer to ASCII digits in a radix of 2 to 10.
// Input word: i_value, taken at a clock edge where start is high and busy
// is low. Output words: o_digit_char with o_last_digit, each valid for one
// cycle while o_valid is high, most significant digit first; o_last_digit
// marks the least significant digit. A zero input gives the single digit '0'.
// Radix: written through i_cfg_we / i_cfg_wdata; the user must write it only
// while busy is low, which the block itself does not enforce. Values below 2
// act as 2, values above 10 act as 10. Reset sets the radix to 10.
// Timing: the front end divides by the radix one quotient bit per cycle and
// finishes all digits before the first is emitted, then emits one digit per
// cycle. A zero input skips the division. The worst case is radix 2 with 63
// digits. Busy stays high until the last digit has been presented; one word
// is handled at a time.
// Reset is synchronous, active low, and returns the block to idle at once.
// The receiver cannot stall: every output word is taken in its cycle.
//

module integer_to_radix_digits (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [itrd_pkg::IN_WIDTH-1:0]  i_value,
    input  logic                           i_cfg_we,
    input  logic [itrd_pkg::RADIX_W-1:0]   i_cfg_wdata,
    output logic                           o_valid,
    output logic [itrd_pkg::CHAR_W-1:0]    o_digit_char,
    output logic                           o_last_digit
);

    import itrd_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic               accept;
    logic               front_idle;
    logic               back_busy;
    logic               job_ready;
    t_job               job;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [DIGIT_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
    logic [DIGIT_W-1:0] rdata;

    // radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_DEFAULT;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_wdata;
        end
    end

    // handshake
    assign busy   = !front_idle || back_busy || job.valid;
    assign accept = start && !busy;

    // digit extraction
    itrd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_value     (i_value),
        .i_radix     (r_radix),
        .o_idle      (front_idle),
        .o_job       (job),
        .i_job_ready (job_ready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata)
    );

    // digit store
    itrd_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // character emission
    itrd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job),
        .o_job_ready  (job_ready),
        .o_busy       (back_busy),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit)
    );

endmodule
